// ----- rtl/lbc_pkg.sv -----
// shared opcode, status and width definitions for the buffer cache tag engine
package lbc_pkg;

  localparam int OP_W     = 3;
  localparam int DISK_W   = 2;
  localparam int BLOCK_W  = 32;
  localparam int SLOT_W   = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 8;

  typedef enum logic [OP_W-1:0] {
    OP_GET     = 3'd0,
    OP_RELEASE = 3'd1,
    OP_VALID   = 3'd2,
    OP_DIRTY   = 3'd3,
    OP_CLEAN   = 3'd4
  } opcode_t;

  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_BUF = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_UNREF  = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

endpackage

// ----- rtl/lru_block_buffer_cache_tags_unit.sv -----
// tag and replacement engine of a disk block buffer cache
// get makes one pass over the slot memory, one read a cycle
// a release that frees a slot also sweeps the memory to update recency
// other release and mark ops read one entry and may write it back; out-of-range and unknown ops skip it
// one item in flight: the next item can be accepted once the result is registered at the output
// reset (synchronous) clears control and all per-entry written bits; an unwritten entry reads as reset
module lru_block_buffer_cache_tags_unit #(
  parameter int SLOT_COUNT = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lbc_pkg::OP_W-1:0]      opcode,
  input  logic [lbc_pkg::DISK_W-1:0]    disk_id,
  input  logic [lbc_pkg::BLOCK_W-1:0]   block_number,
  input  logic [lbc_pkg::SLOT_W-1:0]    slot_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lbc_pkg::SLOT_W-1:0]    result_slot,
  output logic [lbc_pkg::STATUS_W-1:0]  status,
  output logic                          was_hit,
  output logic                          needs_fill
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] CNT_END  = CW'(SLOT_COUNT);
  localparam logic [IW-1:0] RANK_TOP = IW'(SLOT_COUNT - 1);

  // one memory word per slot
  typedef struct packed {
    logic                         present;
    logic [lbc_pkg::DISK_W-1:0]   disk;
    logic [lbc_pkg::BLOCK_W-1:0]  block;
    logic [lbc_pkg::COUNT_W-1:0]  count;
    logic                         valid;
    logic                         dirty;
    logic [IW-1:0]                rank;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_GET_WR, S_MOD, S_SWEEP, S_DONE
  } state_t;

  state_t state;

  // slot memory, synchronous read, plus per-entry written bits
  entry_t                 mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]  written;
  entry_t                 mem_q;
  logic                   q_ok;
  logic [IW-1:0]          q_addr;
  entry_t                 eff;

  logic          rd_en, wr_en, rd_pend;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t        wr_data;

  // captured item
  logic [lbc_pkg::OP_W-1:0]    op_r;
  logic [lbc_pkg::DISK_W-1:0]  disk_r;
  logic [lbc_pkg::BLOCK_W-1:0] blk_r;
  logic [lbc_pkg::SLOT_W-1:0]  slot_r;

  // scan bookkeeping
  logic [CW-1:0] cnt;
  logic          found, have;
  logic [IW-1:0] fidx, bidx, brank;
  entry_t        fent;

  // pending result
  logic [lbc_pkg::SLOT_W-1:0]   res_slot;
  logic [lbc_pkg::STATUS_W-1:0] res_status;
  logic                         res_hit, res_fill;

  logic in_range, acc, is_rmw, match, qual;
  logic [lbc_pkg::COUNT_W-1:0] dec_cnt;

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign in_range = (32'(slot_index) < SLOT_COUNT);
  assign is_rmw   = (opcode == lbc_pkg::OP_RELEASE) || (opcode == lbc_pkg::OP_VALID) ||
                    (opcode == lbc_pkg::OP_DIRTY) || (opcode == lbc_pkg::OP_CLEAN);

  // never written entries read as their reset value
  always_comb begin
    if (q_ok) begin
      eff = mem_q;
    end else begin
      eff         = '0;
      eff.rank    = q_addr;
    end
  end

  assign match   = eff.present && (eff.disk == disk_r) && (eff.block == blk_r);
  assign qual    = (eff.count == '0) && !eff.dirty;
  assign dec_cnt = eff.count - 1'b1;

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = eff;
    unique case (state)
      S_IDLE: begin
        if (acc && is_rmw && in_range) begin
          rd_en   = 1'b1;
          rd_addr = IW'(slot_index);
        end
      end
      S_SCAN: begin
        if (cnt < CNT_END) begin
          rd_en   = 1'b1;
          rd_addr = cnt[IW-1:0];
        end
      end
      S_GET_WR: begin
        if (found) begin
          wr_en   = 1'b1;
          wr_addr = fidx;
          wr_data = fent;
          if (fent.count != lbc_pkg::COUNT_MAX) wr_data.count = fent.count + 1'b1;
        end else if (have) begin
          wr_en           = 1'b1;
          wr_addr         = bidx;
          wr_data.present = 1'b1;
          wr_data.disk    = disk_r;
          wr_data.block   = blk_r;
          wr_data.count   = lbc_pkg::COUNT_W'(1);
          wr_data.valid   = 1'b0;
          wr_data.dirty   = 1'b0;
          wr_data.rank    = brank;
        end
      end
      S_MOD: begin
        wr_addr = q_addr;
        priority case (op_r)
          lbc_pkg::OP_RELEASE: begin
            if (eff.count != '0 && dec_cnt != '0) begin
              wr_en         = 1'b1;
              wr_data.count = dec_cnt;
            end
          end
          lbc_pkg::OP_VALID: begin
            wr_en         = 1'b1;
            wr_data.valid = 1'b1;
          end
          lbc_pkg::OP_DIRTY: begin
            wr_en         = 1'b1;
            wr_data.dirty = 1'b1;
          end
          lbc_pkg::OP_CLEAN: begin
            wr_en         = 1'b1;
            wr_data.dirty = 1'b0;
          end
          default: ;
        endcase
      end
      S_SWEEP: begin
        if (cnt < CNT_END) begin
          rd_en   = 1'b1;
          rd_addr = cnt[IW-1:0];
        end
        // write back the entry read last cycle, never the one being read now
        if (rd_pend) begin
          wr_addr = q_addr;
          if (q_addr == IW'(slot_r)) begin
            wr_en         = 1'b1;
            wr_data.count = '0;
            wr_data.rank  = RANK_TOP;
          end else if (eff.rank > brank) begin
            wr_en        = 1'b1;
            wr_data.rank = eff.rank - 1'b1;
          end
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q  <= mem[rd_addr];
      q_addr <= rd_addr;
    end
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      q_ok    <= 1'b0;
    end else begin
      if (rd_en) q_ok <= written[rd_addr];
      if (wr_en) written[wr_addr] <= 1'b1;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      rd_pend <= rd_en;
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            op_r       <= opcode;
            disk_r     <= disk_id;
            blk_r      <= block_number;
            slot_r     <= slot_index;
            res_slot   <= slot_index;
            res_status <= lbc_pkg::STAT_OK;
            res_hit    <= 1'b0;
            res_fill   <= 1'b0;
            cnt        <= '0;
            found      <= 1'b0;
            have       <= 1'b0;
            if (opcode == lbc_pkg::OP_GET) state <= S_SCAN;
            else if (is_rmw && in_range) state <= S_MOD;
            else state <= S_DONE;
          end
        end
        S_SCAN: begin
          if (cnt < CNT_END) cnt <= cnt + 1'b1;
          if (rd_pend) begin
            // first tag match wins; lowest rank among free clean slots is the victim
            if (match && !found) begin
              found <= 1'b1;
              fidx  <= q_addr;
              fent  <= eff;
            end
            if (qual && (!have || eff.rank < brank)) begin
              have  <= 1'b1;
              bidx  <= q_addr;
              brank <= eff.rank;
            end
          end
          if (cnt == CNT_END && !rd_pend) state <= S_GET_WR;
        end
        S_GET_WR: begin
          if (found) begin
            res_slot <= lbc_pkg::SLOT_W'(fidx);
            res_hit  <= 1'b1;
            res_fill <= !fent.valid;
          end else if (have) begin
            res_slot <= lbc_pkg::SLOT_W'(bidx);
            res_fill <= 1'b1;
          end else begin
            res_slot   <= '0;
            res_status <= lbc_pkg::STAT_NO_BUF;
          end
          state <= S_DONE;
        end
        S_MOD: begin
          if (op_r == lbc_pkg::OP_RELEASE && eff.count != '0 && dec_cnt == '0) begin
            // slot becomes unreferenced: move it to most recent
            brank <= eff.rank;
            cnt   <= '0;
            state <= S_SWEEP;
          end else begin
            if (op_r == lbc_pkg::OP_RELEASE && eff.count == '0) begin
              res_status <= lbc_pkg::STAT_UNREF;
            end
            state <= S_DONE;
          end
        end
        S_SWEEP: begin
          if (cnt < CNT_END) cnt <= cnt + 1'b1;
          if (cnt == CNT_END && !rd_pend) state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            result_slot <= res_slot;
            status      <= res_status;
            was_hit     <= res_hit;
            needs_fill  <= res_fill;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // the sweep write-back never collides with the read in flight
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write to the same slot in one cycle");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while busy");

  // a no-buffer result carries slot zero and no flags
  a_nobuf_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == lbc_pkg::STAT_NO_BUF) |-> (result_slot == '0 && !needs_fill && !was_hit))
    else $error("malformed no-buffer result");

endmodule

// ----- tb/tb_lru_block_buffer_cache_tags_unit.sv -----
// testbench for the buffer cache tag and replacement engine
module tb_lru_block_buffer_cache_tags_unit;

  localparam int SLOTS = 32;

  // one pending lookup result
  typedef struct packed {
    logic [lbc_pkg::SLOT_W-1:0]   slot;
    logic [lbc_pkg::STATUS_W-1:0] stat;
    logic                         hit;
    logic                         fill;
  } cache_reply_t;

  // shadow of the tag store plus the queue of replies still owed
  class cache_scoreboard;
    logic                        present [SLOTS];
    logic [lbc_pkg::DISK_W-1:0]  disk_tag [SLOTS];
    logic [lbc_pkg::BLOCK_W-1:0] block_tag [SLOTS];
    logic [lbc_pkg::COUNT_W-1:0] refs [SLOTS];
    logic                        valid_f [SLOTS];
    logic                        dirty_f [SLOTS];
    int                          rank [SLOTS];
    cache_reply_t                owed [$];
    int                          mismatches;

    function void clear();
      for (int i = 0; i < SLOTS; i++) begin
        present[i] = 0; disk_tag[i] = 0; block_tag[i] = 0; refs[i] = 0;
        valid_f[i] = 0; dirty_f[i] = 0; rank[i] = i;
      end
      owed.delete();
      mismatches = 0;
    endfunction

    // apply one accepted item to the shadow and queue its reply
    function void note_item(logic [lbc_pkg::OP_W-1:0] op, logic [lbc_pkg::DISK_W-1:0] d,
                            logic [lbc_pkg::BLOCK_W-1:0] b, logic [lbc_pkg::SLOT_W-1:0] s);
      cache_reply_t r;
      int found;
      int best;
      int old;
      r = '{slot: s, stat: lbc_pkg::STAT_OK, hit: 1'b0, fill: 1'b0};
      found = -1;
      best = -1;
      case (op)
        lbc_pkg::OP_GET: begin
          for (int i = 0; i < SLOTS && found < 0; i++)
            if (present[i] && disk_tag[i] == d && block_tag[i] == b) found = i;
          if (found >= 0) begin
            if (refs[found] != lbc_pkg::COUNT_MAX) refs[found]++;
            r.slot = lbc_pkg::SLOT_W'(found); r.hit = 1'b1; r.fill = !valid_f[found];
          end else begin
            for (int i = 0; i < SLOTS; i++)
              if (refs[i] == 0 && !dirty_f[i] && (best < 0 || rank[i] < rank[best]))
                best = i;
            if (best >= 0) begin
              present[best] = 1; disk_tag[best] = d; block_tag[best] = b;
              refs[best] = 1; valid_f[best] = 0; dirty_f[best] = 0;
              r.slot = lbc_pkg::SLOT_W'(best); r.fill = 1'b1;
            end else begin
              r.slot = '0; r.stat = lbc_pkg::STAT_NO_BUF;
            end
          end
        end
        lbc_pkg::OP_RELEASE: begin
          if (refs[s] == 0) r.stat = lbc_pkg::STAT_UNREF;
          else begin
            refs[s]--;
            // freed slot moves to the most recent end
            if (refs[s] == 0) begin
              old = rank[s];
              for (int i = 0; i < SLOTS; i++) if (rank[i] > old) rank[i]--;
              rank[s] = SLOTS - 1;
            end
          end
        end
        lbc_pkg::OP_VALID: valid_f[s] = 1;
        lbc_pkg::OP_DIRTY: dirty_f[s] = 1;
        lbc_pkg::OP_CLEAN: dirty_f[s] = 0;
        default: ;
      endcase
      owed.push_back(r);
    endfunction

    function void check_reply(cache_reply_t got);
      cache_reply_t exp;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reply %p", got);
        return;
      end
      exp = owed.pop_front();
      if (exp !== got) begin
        mismatches++;
        if (mismatches <= 10) $display("reply mismatch: expected %p got %p", exp, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [lbc_pkg::OP_W-1:0] opcode = '0;
  logic [lbc_pkg::DISK_W-1:0] disk_id = '0;
  logic [lbc_pkg::BLOCK_W-1:0] block_number = '0;
  logic [lbc_pkg::SLOT_W-1:0] slot_index = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [lbc_pkg::SLOT_W-1:0] result_slot;
  logic [lbc_pkg::STATUS_W-1:0] status;
  logic was_hit;
  logic needs_fill;

  cache_scoreboard sb = new();
  logic start_stall = 1'b0;
  logic long_hold = 1'b0;
  logic [lbc_pkg::BLOCK_W-1:0] hot_blocks [8];

  lru_block_buffer_cache_tags_unit #(.SLOT_COUNT(SLOTS)) u_top (.*);

  always #5 clk = ~clk;

  // input acceptance feeds the shadow model
  always @(posedge clk)
    if (!rst && in_valid && in_ready) sb.note_item(opcode, disk_id, block_number, slot_index);

  // reply side: random stalls plus one long hold-off window
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else begin
      if (out_valid && out_ready)
        sb.check_reply('{slot: result_slot, stat: status, hit: was_hit, fill: needs_fill});
      if (long_hold) out_ready <= 0;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // long hold-off, counted here once the main sequence asks for it
  initial begin
    wait (start_stall);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (300) @(posedge clk);
    long_hold <= 1'b0;
  end

  // present one item and hold it until taken
  task automatic send_item(logic [lbc_pkg::OP_W-1:0] op, logic [lbc_pkg::DISK_W-1:0] d,
                           logic [lbc_pkg::BLOCK_W-1:0] b, logic [lbc_pkg::SLOT_W-1:0] s);
    in_valid <= 1; opcode <= op; disk_id <= d; block_number <= b; slot_index <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  // gets most often, on a small working set so hits and refcounts build up
  task automatic send_random();
    int sel;
    logic [lbc_pkg::OP_W-1:0] op;
    sel = $urandom_range(0, 99);
    if (sel < 45) op = lbc_pkg::OP_GET;
    else if (sel < 75) op = lbc_pkg::OP_RELEASE;
    else if (sel < 83) op = lbc_pkg::OP_VALID;
    else if (sel < 90) op = lbc_pkg::OP_DIRTY;
    else if (sel < 97) op = lbc_pkg::OP_CLEAN;
    else op = lbc_pkg::OP_W'($urandom_range(5, 7));
    send_item(op, lbc_pkg::DISK_W'($urandom_range(0, 3)),
              ($urandom_range(0, 3) != 0) ? hot_blocks[$urandom_range(0, 7)] : $urandom,
              lbc_pkg::SLOT_W'($urandom_range(0, 31)));
  endtask

  initial begin
    int burst;
    sb.clear();
    for (int i = 0; i < 8; i++) hot_blocks[i] = $urandom;
    hot_blocks[0] = '0; hot_blocks[1] = '1;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: field extremes, every op, unref release, unknown op
    send_item(lbc_pkg::OP_GET, 2'd0, 32'h0, 5'd0);
    send_item(lbc_pkg::OP_GET, 2'd3, 32'hFFFF_FFFF, 5'd31);
    send_item(lbc_pkg::OP_GET, 2'd0, 32'h0, 5'd5);          // hit, not yet valid
    send_item(lbc_pkg::OP_VALID, 2'd0, 32'h0, 5'd0);
    send_item(lbc_pkg::OP_GET, 2'd0, 32'h0, 5'd0);          // hit, valid
    send_item(lbc_pkg::OP_RELEASE, 2'd0, 32'h0, 5'd31);     // slot 31 unreferenced
    send_item(lbc_pkg::OP_RELEASE, 2'd0, 32'h0, 5'd7);      // unreferenced
    send_item(lbc_pkg::OP_DIRTY, 2'd0, 32'h0, 5'd2);
    send_item(lbc_pkg::OP_CLEAN, 2'd0, 32'h0, 5'd2);
    send_item(lbc_pkg::OP_DIRTY, 2'd0, 32'h0, 5'd3);
    send_item(3'd5, 2'd2, 32'h1234_5678, 5'd17);
    send_item(3'd7, 2'd1, 32'h8765_4321, 5'd31);
    send_item(3'd6, 2'd3, 32'hAAAA_5555, 5'd0);
    // fill the cache until no buffer is left
    for (int i = 0; i < 33; i++)
      send_item(lbc_pkg::OP_GET, 2'd1, 32'h100 + 32'(i), 5'd0);
    // saturate one count to 255 and release it down to zero and past it
    for (int i = 0; i < 260; i++) send_item(lbc_pkg::OP_GET, 2'd1, 32'h100, 5'd0);
    for (int i = 0; i < 260; i++) send_item(lbc_pkg::OP_RELEASE, 2'd0, 32'h0, 5'd2);
    // drain all references so random traffic starts from a usable cache
    for (int s = 0; s < SLOTS; s++) begin
      send_item(lbc_pkg::OP_CLEAN, 2'd0, 32'h0, lbc_pkg::SLOT_W'(s));
      repeat (3) send_item(lbc_pkg::OP_RELEASE, 2'd0, 32'h0, lbc_pkg::SLOT_W'(s));
    end

    // long receiver hold-off while items keep coming
    start_stall = 1'b1;
    for (int i = 0; i < 20; i++) send_random();

    for (int n = 0; n < 220; ) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst; k++) send_random();
      n += burst;
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 40));
    end
    in_valid <= 0;

    while (sb.owed.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (sb.mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/lbc_pkg.sv
rtl/lru_block_buffer_cache_tags_unit.sv
tb/tb_lru_block_buffer_cache_tags_unit.sv
